/* rtl/core/assert_macros.svh */
// Assertion macros shared by the profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while rst_n is low.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tetp_pkg.sv */
// Types, constants and state encodings of the task execution time profiler.
package tetp_pkg;

  localparam int unsigned NUM_TASKS_DEF = 16;
  localparam int unsigned TIME_W        = 29;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned LOAD_W        = 16;
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned TASK_W        = 4;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned SCALE_W       = 15;
  localparam int unsigned PROD_W        = WORD_W + SCALE_W;

  localparam logic [TIME_W-1:0]  TIMER_PERIOD_US = 29'd429496730;
  localparam logic [WORD_W-1:0]  LOAD_WINDOW_RST = 32'd200000;
  // 100 percent times 256 for the Q8 fraction.
  localparam logic [SCALE_W-1:0] LOAD_SCALE      = 15'd25600;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENTRY = 2'd0,
    FN_EXIT  = 2'd1,
    FN_CALC  = 2'd2
  } tetp_func_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_index;
    logic [TIME_W-1:0] time_us;
  } tetp_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed_us;
    logic [TIME_W-1:0] max_elapsed;
    logic [WORD_W-1:0] min_elapsed;
    logic [TIME_W-1:0] avg_elapsed;
    logic [WORD_W-1:0] window_sum;
    logic [LOAD_W-1:0] load_percent_q8;
  } tetp_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] entry_stamp;
    logic [TIME_W-1:0] max_time;
    logic [WORD_W-1:0] min_time;
    logic [TIME_W-1:0] avg_time;
    logic [WORD_W-1:0] sum_time;
  } tetp_rec_t;

  localparam int unsigned REC_W = $bits(tetp_rec_t);

  localparam tetp_rec_t REC_RST = '{
    entry_stamp: '0,
    max_time:    '0,
    min_time:    '1,
    avg_time:    '0,
    sum_time:    '0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_UPD,
    ST_WALK,
    ST_LOAD,
    ST_DONE
  } tetp_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHK,
    DV_ITER
  } tetp_div_state_t;

endpackage

/* rtl/core/task_execution_time_profiler_top.sv */
// Task execution time profiler: per-task timing records in one RAM, read-modify-write.
// Entry and exit items with an in-range task index pass through the RAM read, the update and
// write, and the result register before the next ready; the result waits while the output is held.
// A calculate item walks all NUM_TASKS records through the RAM port, clearing each sum,
// and then runs the 16-step load divider.
// Reset clears control state and the per-task valid bits, so every record reads as reset.
`include "assert_macros.svh"

module task_execution_time_profiler_top #(
  parameter int unsigned NUM_TASKS = tetp_pkg::NUM_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tetp_pkg::tetp_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tetp_pkg::tetp_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tetp_pkg::WORD_W-1:0] cfg_load_window_us
);
  import tetp_pkg::*;

  localparam int unsigned AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [IDX_W-1:0] NUM_TASKS_I = IDX_W'(NUM_TASKS);
  localparam logic [CW-1:0]    LAST_CNT    = CW'(NUM_TASKS);

  tetp_state_t          state_r, state_nxt;
  tetp_in_t             in_r, in_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  tetp_rec_t            rec_r, rec_nxt;
  logic [TIME_W-1:0]    el_r, el_nxt;
  tetp_out_t            res_r, res_nxt;
  tetp_out_t            out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    win_r;
  logic [CW-1:0]        wc_r, wc_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        paddr_r, paddr_nxt;
  logic [WORD_W-1:0]    total_r, total_nxt;
  logic [NUM_TASKS-1:0] valid_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  tetp_rec_t            ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [REC_W-1:0]     ram_rdata;

  logic                 div_start;
  logic                 div_done;
  logic [LOAD_W-1:0]    div_load;

  logic [IDX_W-1:0]     idx_ext;
  logic                 idx_ok;
  logic [AW-1:0]        idx_addr;
  logic                 sel_valid;
  tetp_rec_t            cur_rec;
  tetp_rec_t            upd_rec;
  tetp_rec_t            walk_rec;
  logic [TIME_W-1:0]    diff;
  logic [TIME_W-1:0]    el_new;
  logic [TIME_W:0]      avg_sum;

  tetp_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TASKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tetp_load u_load (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .total  (total_r),
    .window (win_r),
    .done   (div_done),
    .load   (div_load)
  );

  assign idx_ext  = IDX_W'(in_data.task_index);
  assign idx_ok   = idx_ext < NUM_TASKS_I;
  assign idx_addr = idx_ext[AW-1:0];

  // A record never written since reset reads as its reset value.
  assign sel_valid = (state_r == ST_WALK) ? valid_r[paddr_r] : valid_r[addr_r];
  assign cur_rec   = sel_valid ? tetp_rec_t'(ram_rdata) : REC_RST;

  // When the exit time is not above the entry time the timer has wrapped once.
  assign diff   = in_r.time_us - cur_rec.entry_stamp;
  assign el_new = (in_r.time_us > cur_rec.entry_stamp) ? diff : diff + TIMER_PERIOD_US;

  assign avg_sum = {1'b0, el_r} + {1'b0, rec_r.avg_time};

  always_comb begin
    upd_rec = rec_r;
    if (in_r.func == FN_ENTRY) begin
      upd_rec.entry_stamp = in_r.time_us;
    end else begin
      if (rec_r.max_time < el_r) begin
        upd_rec.max_time = el_r;
      end
      if (rec_r.min_time > WORD_W'(el_r)) begin
        upd_rec.min_time = WORD_W'(el_r);
      end
      upd_rec.avg_time = (rec_r.avg_time == '0) ? el_r : avg_sum[TIME_W:1];
      upd_rec.sum_time = rec_r.sum_time + WORD_W'(el_r);
    end
  end

  always_comb begin
    walk_rec          = cur_rec;
    walk_rec.sum_time = '0;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    addr_nxt      = addr_r;
    rec_nxt       = rec_r;
    el_nxt        = el_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wc_nxt        = wc_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    total_nxt     = total_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = upd_rec;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt   = in_data;
          addr_nxt = idx_addr;
          res_nxt  = '0;
          if (in_data.func == FN_CALC) begin
            wc_nxt    = '0;
            pend_nxt  = 1'b0;
            total_nxt = '0;
            state_nxt = ST_WALK;
          end else if ((in_data.func == FN_ENTRY || in_data.func == FN_EXIT) && idx_ok) begin
            ram_re    = 1'b1;
            ram_raddr = idx_addr;
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RD: begin
        rec_nxt   = cur_rec;
        el_nxt    = el_new;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = upd_rec;
        if (in_r.func == FN_EXIT) begin
          res_nxt.elapsed_us = el_r;
        end
        res_nxt.max_elapsed = upd_rec.max_time;
        res_nxt.min_elapsed = upd_rec.min_time;
        res_nxt.avg_elapsed = upd_rec.avg_time;
        state_nxt = ST_DONE;
      end
      ST_WALK: begin
        // Reads run one record ahead of the write-back that clears its sum.
        if (wc_r < LAST_CNT) begin
          ram_re    = 1'b1;
          ram_raddr = wc_r[AW-1:0];
          paddr_nxt = wc_r[AW-1:0];
          wc_nxt    = wc_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          total_nxt = total_r + cur_rec.sum_time;
          ram_we    = 1'b1;
          ram_waddr = paddr_r;
          ram_wdata = walk_rec;
        end
        if (wc_r == LAST_CNT && !pend_r) begin
          res_nxt.window_sum = total_r;
          div_start          = 1'b1;
          state_nxt          = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (div_done) begin
          res_nxt.load_percent_q8 = div_load;
          state_nxt               = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wc_r        <= '0;
      pend_r      <= 1'b0;
      win_r       <= LOAD_WINDOW_RST;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wc_r        <= wc_nxt;
      pend_r      <= pend_nxt;
      if (cfg_valid) begin
        win_r <= cfg_load_window_us;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    addr_r     <= addr_nxt;
    rec_r      <= rec_nxt;
    el_r       <= el_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    paddr_r    <= paddr_nxt;
    total_r    <= total_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_RST(a_one_item_at_a_time, (in_valid && in_ready) |=> !in_ready, "item accepted while busy")
  `ASSERT_RST(a_write_in_range, ram_we |-> (IDX_W'(ram_waddr) < NUM_TASKS_I), "record write out of range")
  `ASSERT_RST(a_div_done_in_load, div_done |-> (state_r == ST_LOAD), "load result outside load wait")
  `ASSERT_CLK(a_reset_clears_out, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

/* rtl/core/tetp_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module tetp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/tetp_load.sv */
// Load computation: total times 25600, divided by the window one bit a cycle, saturated.
`include "assert_macros.svh"

module tetp_load (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tetp_pkg::WORD_W-1:0] total,
  input  logic [tetp_pkg::WORD_W-1:0] window,
  output logic                        done,
  output logic [tetp_pkg::LOAD_W-1:0] load
);
  import tetp_pkg::*;

  localparam int unsigned CNT_W = $clog2(LOAD_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(LOAD_W - 1);

  tetp_div_state_t   state_r, state_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [WORD_W-1:0] win_r, win_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [LOAD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  logic [WORD_W:0]   hi_ext;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign hi_ext = (WORD_W + 1)'(prod_r[PROD_W-1:LOAD_W]);
  assign trial  = {rem_r, prod_r[LOAD_W-1]};
  assign diff   = trial - {1'b0, win_r};

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    win_nxt   = win_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          prod_nxt  = PROD_W'(total) * PROD_W'(LOAD_SCALE);
          win_nxt   = window;
          state_nxt = DV_CHK;
        end
      end
      DV_CHK: begin
        // A quotient above 16 bits shows in the high part already; a zero window lands here too.
        if (hi_ext >= {1'b0, win_r}) begin
          quo_nxt   = '1;
          done_nxt  = 1'b1;
          state_nxt = DV_IDLE;
        end else begin
          rem_nxt   = hi_ext[WORD_W-1:0];
          cnt_nxt   = '0;
          state_nxt = DV_ITER;
        end
      end
      DV_ITER: begin
        if (trial >= {1'b0, win_r}) begin
          rem_nxt = diff[WORD_W-1:0];
          quo_nxt = {quo_r[LOAD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[WORD_W-1:0];
          quo_nxt = {quo_r[LOAD_W-2:0], 1'b0};
        end
        prod_nxt = prod_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_BIT) begin
          done_nxt  = 1'b1;
          state_nxt = DV_IDLE;
        end
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    win_r  <= win_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign load = quo_r;

  `ASSERT_RST(a_rem_below_window, (state_r == DV_ITER) |-> (rem_r < win_r), "remainder not below window")

endmodule

/* test/task_execution_time_profiler_checker.sv */
// Checker for the task profiler: predicts every result from the accepted items and compares it.
`timescale 1ns / 1ps

module task_execution_time_profiler_checker
  import tetp_pkg::*;
#(
  parameter int unsigned NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  tetp_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  tetp_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_load_window_us,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  localparam logic [31:0] WRAP_PERIOD_US = 32'd429496730;
  localparam logic [31:0] TIME_MASK      = 32'h1FFF_FFFF;
  localparam logic [63:0] Q8_HUNDRED     = 64'd25600;
  localparam logic [63:0] LOAD_MAX       = 64'd65535;
  localparam logic [31:0] WINDOW_DEFAULT = 32'd200000;

  logic [28:0] stamp_us [NUM_TASKS];
  logic [28:0] worst_us [NUM_TASKS];
  logic [31:0] best_us  [NUM_TASKS];
  logic [28:0] mean_us  [NUM_TASKS];
  logic [31:0] total_us [NUM_TASKS];
  logic [31:0] window_us;

  tetp_out_t expected_reports[$];
  tetp_out_t want;

  // Applies one item to the mirrored task table and returns the report it should produce.
  function automatic tetp_out_t profile_event(input tetp_in_t ev);
    tetp_out_t   rep;
    logic [31:0] now;
    logic [31:0] start;
    logic [31:0] el;
    logic [31:0] grand;
    logic [63:0] load;
    int unsigned i;
    rep = '0;
    i = ev.task_index;
    now = {3'b000, ev.time_us};
    case (ev.func)
      FN_CALC: begin
        grand = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
          grand += total_us[t];
          total_us[t] = '0;
        end
        if (window_us == '0) begin
          load = LOAD_MAX;
        end else begin
          load = ({32'd0, grand} * Q8_HUNDRED) / {32'd0, window_us};
          if (load > LOAD_MAX) load = LOAD_MAX;
        end
        rep.window_sum = grand;
        rep.load_percent_q8 = load[15:0];
      end
      FN_ENTRY, FN_EXIT: begin
        if (i < NUM_TASKS) begin
          if (ev.func == FN_ENTRY) begin
            stamp_us[i] = ev.time_us;
          end else begin
            start = {3'b000, stamp_us[i]};
            // An exit at or before the stored entry means the timer rolled over.
            if (now > start) el = now - start;
            else el = (WRAP_PERIOD_US + now - start) & TIME_MASK;
            if ({3'b000, worst_us[i]} < el) worst_us[i] = el[28:0];
            if (best_us[i] > el) best_us[i] = el;
            if (mean_us[i] == '0) mean_us[i] = el[28:0];
            else mean_us[i] = 29'((el + {3'b000, mean_us[i]}) >> 1);
            total_us[i] += el;
            rep.elapsed_us = el[28:0];
          end
          rep.max_elapsed = worst_us[i];
          rep.min_elapsed = best_us[i];
          rep.avg_elapsed = mean_us[i];
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0d (0x%08h), got %0d (0x%08h)", $time, field,
               exp_v, exp_v, got_v, got_v);
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        stamp_us[t] = '0;
        worst_us[t] = '0;
        best_us[t]  = '1;
        mean_us[t]  = '0;
        total_us[t] = '0;
      end
      window_us = WINDOW_DEFAULT;
      expected_reports.delete();
    end else begin
      // A report leaving now always belongs to an earlier item, so check it first.
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, got %p", $time, out_data);
        end else begin
          want = expected_reports.pop_front();
          check_field("elapsed_us", 32'(want.elapsed_us), 32'(out_data.elapsed_us));
          check_field("max_elapsed", 32'(want.max_elapsed), 32'(out_data.max_elapsed));
          check_field("min_elapsed", want.min_elapsed, out_data.min_elapsed);
          check_field("avg_elapsed", 32'(want.avg_elapsed), 32'(out_data.avg_elapsed));
          check_field("window_sum", want.window_sum, out_data.window_sum);
          check_field("load_percent_q8", 32'(want.load_percent_q8),
                      32'(out_data.load_percent_q8));
        end
      end
      if (cfg_valid && cfg_ready) window_us = cfg_load_window_us;
      if (in_valid && in_ready) expected_reports.push_back(profile_event(in_data));
    end
    pending = expected_reports.size();
  end

endmodule

/* test/task_execution_time_profiler_top_tb.sv */
// Testbench top for the task profiler: clock, reset, item and window stimulus, verdict.
`timescale 1ns / 1ps

module task_execution_time_profiler_top_tb;
  import tetp_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int unsigned       WRAP_US   = 429496730;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tetp_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  tetp_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_load_window_us;

  int mismatches;
  int pending;
  int results_seen;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_cycles;
  int unsigned items_sent;
  int unsigned windows_written;
  int unsigned clock_us;
  int unsigned entry_us [16];

  task_execution_time_profiler_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_load_window_us(cfg_load_window_us)
  );

  task_execution_time_profiler_checker profile_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_load_window_us(cfg_load_window_us),
    .mismatches        (mismatches),
    .pending           (pending),
    .results_seen      (results_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic tetp_in_t make_event(input logic [FUNC_W-1:0] fn,
                                          input logic [TASK_W-1:0] idx,
                                          input logic [TIME_W-1:0] stamp);
    tetp_in_t ev;
    ev.func = fn;
    ev.task_index = idx;
    ev.time_us = stamp;
    return ev;
  endfunction

  task automatic send_event(input tetp_in_t ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_window(input logic [31:0] value);
    // The last item is already taken, so nothing is offered while the window changes.
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_load_window_us <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    windows_written++;
  endtask

  // Mostly entry/exit pairs on a running clock, with calculate items, unused codes and noise.
  task automatic run_random(input int unsigned count);
    tetp_in_t    ev;
    int unsigned pick;
    int unsigned delta;
    logic [3:0]  t;
    logic [31:0] raw;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      t = 4'($urandom_range(0, 15));
      raw = $urandom;
      clock_us = (clock_us + $urandom_range(1, 2000)) % WRAP_US;
      if (pick < 38) begin
        ev = make_event(FN_ENTRY, t, 29'(clock_us));
        entry_us[t] = clock_us;
      end else if (pick < 78) begin
        case ($urandom_range(0, 19))
          0:       delta = 0;
          1, 2, 3: delta = raw % WRAP_US;
          default: delta = $urandom_range(1, 3000);
        endcase
        ev = make_event(FN_EXIT, t, 29'((entry_us[t] + delta) % WRAP_US));
      end else if (pick < 86) begin
        ev = make_event(FN_CALC, t, raw[28:0]);
      end else if (pick < 90) begin
        ev = make_event(FN_UNUSED, t, raw[28:0]);
      end else begin
        ev = make_event(pick[0] ? FN_EXIT : FN_ENTRY, t, raw[28:0]);
      end
      send_event(ev);
    end
  endtask

  initial begin
    logic [31:0] window;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_load_window_us = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    items_sent = 0;
    windows_written = 0;
    clock_us = 0;
    foreach (entry_us[k]) entry_us[k] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners, starting from the reset window.
    send_event(make_event(FN_CALC, 4'd0, 29'd0));
    send_event(make_event(FN_ENTRY, 4'd0, 29'd0));
    send_event(make_event(FN_EXIT, 4'd0, 29'd0));
    send_event(make_event(FN_ENTRY, 4'd15, '1));
    send_event(make_event(FN_EXIT, 4'd15, 29'd0));
    send_event(make_event(FN_ENTRY, 4'd5, 29'd100));
    send_event(make_event(FN_EXIT, 4'd5, 29'd101));
    send_event(make_event(FN_EXIT, 4'd5, 29'd101));
    // An entry one full timer period ahead of the exit gives zero elapsed time.
    send_event(make_event(FN_ENTRY, 4'd3, 29'd429496730));
    send_event(make_event(FN_EXIT, 4'd3, 29'd0));
    send_event(make_event(FN_ENTRY, 4'd9, 29'd12345));
    send_event(make_event(FN_UNUSED, '1, '1));
    send_event(make_event(FN_EXIT, 4'd7, 29'd429496729));
    send_event(make_event(FN_CALC, '1, '1));
    send_event(make_event(FN_CALC, 4'd0, 29'd0));
    write_window(32'd1);
    send_event(make_event(FN_ENTRY, 4'd2, 29'd0));
    send_event(make_event(FN_EXIT, 4'd2, 29'd1000));
    send_event(make_event(FN_CALC, 4'd0, 29'd0));
    write_window(32'd0);
    send_event(make_event(FN_EXIT, 4'd2, 29'd5));
    send_event(make_event(FN_CALC, 4'd0, 29'd0));
    write_window(32'hFFFF_FFFF);
    send_event(make_event(FN_ENTRY, 4'd4, 29'd0));
    send_event(make_event(FN_EXIT, 4'd4, 29'd429496729));
    send_event(make_event(FN_CALC, 4'd0, 29'd0));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       window = $urandom;
        1:       window = $urandom_range(1, 100000);
        2:       window = 32'd200000;
        default: window = 32'hFFFF_FFFF;
      endcase
      write_window(window);
      tx_idle_pct  = (p == 1) ? 63 : (p == 3) ? 36 : 0;
      rx_stall_pct = (p == 2) ? 63 : (p == 3) ? 36 : 0;
      run_random(200);
      if (p == 0) begin
        // Hold the result side long enough for the block to back up onto its input.
        hold_cycles = 150;
        run_random(30);
      end
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("Sent %0d items under four idle mixes and one long result hold-off,", items_sent);
    $display("with %0d window writes; %0d results compared.", windows_written, results_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
